FILE: rtl/dssm_pkg.sv
package dssm_pkg;

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_POP  = 2'd1,
		ACT_DUMP = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    push_wr;
		logic    pop_start;
		logic    dump_start;
		logic    advance;
		logic    out_load;
		status_t out_status;
		logic    out_use_data;
		logic    out_last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic in_empty;
		logic cur_zero;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/dssm_ctrl.sv
module dssm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic [1:0]        in_action,
	output logic              s_tready,
	input  dssm_pkg::sts_t    sts,
	output dssm_pkg::cmd_t    cmd
);

	typedef enum logic {
		S_IDLE,
		S_STREAM
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign s_tready = (state_q == S_IDLE) && sts.out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd              = '0;
		cmd.out_status   = dssm_pkg::ST_OK;
		state_nxt        = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_action)
						dssm_pkg::ACT_PUSH: begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							if (sts.full) begin
								cmd.out_status = dssm_pkg::ST_FULL;
							end else begin
								cmd.push_wr = 1'b1;
							end
						end
						dssm_pkg::ACT_POP: begin
							if (sts.in_empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_last   = 1'b1;
								cmd.out_status = dssm_pkg::ST_EMPTY;
							end else begin
								cmd.pop_start = 1'b1;
								state_nxt     = S_STREAM;
							end
						end
						dssm_pkg::ACT_DUMP: begin
							if (sts.in_empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_last   = 1'b1;
								cmd.out_status = dssm_pkg::ST_EMPTY;
							end else begin
								cmd.dump_start = 1'b1;
								state_nxt      = S_STREAM;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_STREAM: begin
				if (sts.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_use_data = 1'b1;
					cmd.out_last     = sts.cur_zero;
					if (sts.cur_zero) begin
						state_nxt = S_IDLE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: rtl/dssm_dp.sv
module dssm_dp #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dssm_pkg::cmd_t    cmd,
	output dssm_pkg::sts_t    sts,
	input  logic              in_stack,
	input  logic [31:0]       in_value,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [31:0]       m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] TOP_IDX  = AW'(DEPTH - 1);
	localparam logic [CW:0]   CAPACITY = (CW + 1)'(DEPTH);

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;
	logic [CW-1:0] lower_cnt_q;
	logic [CW-1:0] upper_cnt_q;
	logic [AW-1:0] cursor_q;
	logic          stack_q;
	logic          out_valid_q;
	logic [31:0]   out_data_q;
	logic [1:0]    out_status_q;
	logic          out_last_q;

	logic [CW-1:0] n_in;
	logic [CW-1:0] n_in_m1;
	logic [AW-1:0] top_pos;
	logic [AW-1:0] cur_m1;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic          out_free;

	function automatic logic [AW-1:0] slot(input logic upper, input logic [AW-1:0] pos);
		return upper ? (TOP_IDX - pos) : pos;
	endfunction

	assign n_in    = in_stack ? upper_cnt_q : lower_cnt_q;
	assign n_in_m1 = n_in - CW'(1);
	assign top_pos = n_in_m1[AW-1:0];
	assign cur_m1  = cursor_q - AW'(1);
	assign wr_addr = slot(in_stack, n_in[AW-1:0]);
	assign rd_en   = cmd.pop_start || cmd.dump_start || cmd.advance;
	assign rd_addr = cmd.advance ? slot(stack_q, cur_m1) : slot(in_stack, top_pos);
	assign out_free = !out_valid_q || m_tready;

	assign sts.full     = ({1'b0, lower_cnt_q} + {1'b0, upper_cnt_q}) >= CAPACITY;
	assign sts.in_empty = (n_in == '0);
	assign sts.cur_zero = (cursor_q == '0);
	assign sts.out_free = out_free;

	always_ff @(posedge clk) begin
		if (cmd.push_wr) begin
			mem[wr_addr] <= in_value;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_cnt_q <= '0;
			upper_cnt_q <= '0;
			cursor_q    <= '0;
			stack_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push_wr) begin
				if (in_stack) begin
					upper_cnt_q <= upper_cnt_q + CW'(1);
				end else begin
					lower_cnt_q <= lower_cnt_q + CW'(1);
				end
			end else if (cmd.pop_start) begin
				if (in_stack) begin
					upper_cnt_q <= n_in_m1;
				end else begin
					lower_cnt_q <= n_in_m1;
				end
			end
			if (cmd.pop_start) begin
				cursor_q <= '0;
				stack_q  <= in_stack;
			end else if (cmd.dump_start) begin
				cursor_q <= top_pos;
				stack_q  <= in_stack;
			end else if (cmd.advance) begin
				cursor_q <= cur_m1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q   <= cmd.out_use_data ? rdata_q : 32'd0;
			out_status_q <= cmd.out_status;
			out_last_q   <= cmd.out_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: rtl/dual_stack_shared_memory.sv
// Push, and pop or dump of an empty stack: result in the cycle after the transaction, one per cycle while not stalled.
// Pop: the element goes to the read register, then the output register; the next transaction waits for that load.
// Dump of n elements: the top element passes the read and output registers, then one per cycle while not stalled.
// Pop and dump rates are set by the single registered read port of the shared store.
// Reset clears both stack counts and the output valid flag; the store itself is not cleared.
module dual_stack_shared_memory #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // push_value
	input  logic [2:0]  s_tuser,   // action[1:0], which_stack[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // element
	output logic [1:0]  m_tuser,   // status
	output logic        m_tlast
);

	dssm_pkg::cmd_t cmd;
	dssm_pkg::sts_t sts;

	dssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.in_action (s_tuser[1:0]),
		.s_tready  (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dssm_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_stack (s_tuser[2]),
		.in_value (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: rtl/dssm_chk.sv
module dssm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("output changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == dssm_pkg::ST_OK || m_tuser == dssm_pkg::ST_EMPTY
		|| m_tuser == dssm_pkg::ST_FULL))
		else $error("bad status code");

	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != dssm_pkg::ST_OK |-> m_tdata == 32'd0 && m_tlast)
		else $error("failed request not a single zero result");

	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[1:0] == dssm_pkg::ACT_PUSH
		|=> m_tvalid && m_tlast && m_tdata == 32'd0)
		else $error("push result missing");

	a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken during a dump");

endmodule

bind dual_stack_shared_memory dssm_chk u_chk (.*);

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int DEPTH = 64;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	class stack_scoreboard;
		typedef struct {
			dssm_pkg::status_t status;
			logic [31:0]       element;
			logic              last;
		} result_t;

		logic [31:0] store [DEPTH];
		int unsigned count [2];
		result_t     awaited [$];
		int          errors;
		int          results_seen;
		int          refused_pushes;
		int          longest_dump;

		function new();
			count[0] = 0;
			count[1] = 0;
			errors = 0;
			results_seen = 0;
			refused_pushes = 0;
			longest_dump = 0;
		endfunction

		function int unsigned slot(bit upper, int unsigned pos);
			return upper ? DEPTH - 1 - pos : pos;
		endfunction

		function int unsigned occupancy();
			return count[0] + count[1];
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void await_result(dssm_pkg::status_t st, logic [31:0] el, logic last);
			result_t r;
			r.status = st;
			r.element = el;
			r.last = last;
			awaited.push_back(r);
		endfunction

		// work out the results of one accepted input transaction
		function void note_item(logic [1:0] act, bit upper, logic [31:0] val);
			case (act)
				dssm_pkg::ACT_PUSH: begin
					if (occupancy() >= DEPTH) begin
						await_result(dssm_pkg::ST_FULL, 32'd0, 1'b1);
						refused_pushes++;
					end else begin
						store[slot(upper, count[upper])] = val;
						count[upper]++;
						await_result(dssm_pkg::ST_OK, 32'd0, 1'b1);
					end
				end
				dssm_pkg::ACT_POP: begin
					if (count[upper] == 0) begin
						await_result(dssm_pkg::ST_EMPTY, 32'd0, 1'b1);
					end else begin
						count[upper]--;
						await_result(dssm_pkg::ST_OK, store[slot(upper, count[upper])], 1'b1);
					end
				end
				dssm_pkg::ACT_DUMP: begin
					if (count[upper] == 0) begin
						await_result(dssm_pkg::ST_EMPTY, 32'd0, 1'b1);
					end else begin
						for (int i = count[upper]; i > 0; i--)
							await_result(dssm_pkg::ST_OK, store[slot(upper, i - 1)], i == 1);
						if (count[upper] > longest_dump)
							longest_dump = count[upper];
					end
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH at %0t: %s", $time, msg);
		endtask

		task check_result(dssm_pkg::status_t st, logic [31:0] el, logic last);
			result_t r;
			results_seen++;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result status %0d element %h last %0b",
					st, el, last));
			end else begin
				r = awaited.pop_front();
				if (st !== r.status || el !== r.element || last !== r.last)
					report($sformatf("got status %0d element %h last %0b, want %0d %h %0b",
						st, el, last, r.status, r.element, r.last));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;   // action[1:0], which_stack[2]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // element
	logic [1:0]  m_tuser;        // status
	logic        m_tlast;

	stack_scoreboard sb;
	bit no_idle = 1'b0;
	int seg_left = 0;
	int rx_hold = 0;
	int items_sent = 0;
	int items_ignored = 0;

	dual_stack_shared_memory #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Timeout");
		$display("Regression FAIL");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic bit rand_side();
		return 1'($urandom_range(0, 1));
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(dssm_pkg::status_t'(m_tuser), m_tdata, m_tlast);
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
		end else if (no_idle || !m_tready) begin
			m_tready <= 1'b1;
			rx_hold <= $urandom_range(0, 6);
		end else begin
			rx_hold <= pick_gap();
			if (pick_gap() > 0)
				m_tready <= 1'b0;
		end
	end

	task automatic send_item(input logic [1:0] act, input bit upper, input logic [31:0] val);
		int gap;
		gap = pick_gap();
		if (seg_left == 0) begin
			no_idle <= ($urandom_range(0, 3) == 0);
			seg_left = $urandom_range(10, 30);
		end else begin
			seg_left--;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		s_tuser <= {upper, act};
		do @(posedge clk); while (!s_tready);
		sb.note_item(act, upper, val);
		if (act == ACT_UNUSED)
			items_ignored++;
		else
			items_sent++;
	endtask

	task automatic random_item(int w_push, int w_pop, int w_dump);
		int r;
		r = $urandom_range(0, w_push + w_pop + w_dump + 4);
		if (r < w_push)
			send_item(dssm_pkg::ACT_PUSH, rand_side(), rand_value());
		else if (r < w_push + w_pop)
			send_item(dssm_pkg::ACT_POP, rand_side(), rand_value());
		else if (r < w_push + w_pop + w_dump)
			send_item(dssm_pkg::ACT_DUMP, rand_side(), rand_value());
		else
			send_item(ACT_UNUSED, rand_side(), rand_value());
	endtask

	initial begin
		int lean;
		int r;
		bit side;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stacks, field extremes, single and multi element dumps
		send_item(dssm_pkg::ACT_POP, 1'b0, 32'h0);
		send_item(dssm_pkg::ACT_POP, 1'b1, 32'hffff_ffff);
		send_item(dssm_pkg::ACT_DUMP, 1'b0, 32'h0);
		send_item(dssm_pkg::ACT_DUMP, 1'b1, 32'h0);
		send_item(ACT_UNUSED, 1'b0, 32'h1234_5678);
		send_item(dssm_pkg::ACT_PUSH, 1'b0, 32'h7fff_ffff);
		send_item(dssm_pkg::ACT_PUSH, 1'b0, 32'h8000_0000);
		send_item(dssm_pkg::ACT_PUSH, 1'b0, 32'h0000_0000);
		send_item(dssm_pkg::ACT_PUSH, 1'b1, 32'hffff_ffff);
		send_item(dssm_pkg::ACT_PUSH, 1'b1, 32'h0000_0001);
		send_item(dssm_pkg::ACT_DUMP, 1'b0, 32'h0);
		send_item(dssm_pkg::ACT_DUMP, 1'b1, 32'h0);
		send_item(dssm_pkg::ACT_POP, 1'b0, 32'h0);
		send_item(dssm_pkg::ACT_POP, 1'b1, 32'h0);
		send_item(ACT_UNUSED, 1'b1, 32'hffff_ffff);
		send_item(dssm_pkg::ACT_DUMP, 1'b1, 32'h0);
		send_item(dssm_pkg::ACT_POP, 1'b1, 32'h0);
		send_item(dssm_pkg::ACT_POP, 1'b1, 32'h0);
		send_item(dssm_pkg::ACT_DUMP, 1'b0, 32'h0);
		send_item(dssm_pkg::ACT_POP, 1'b0, 32'h0);
		send_item(dssm_pkg::ACT_POP, 1'b0, 32'h0);
		send_item(dssm_pkg::ACT_POP, 1'b0, 32'h0);

		// fill the store until the stacks meet, then refused pushes and full dumps
		lean = $urandom_range(10, 90);
		while (sb.occupancy() < DEPTH) begin
			r = $urandom_range(0, 99);
			side = ($urandom_range(0, 99) < lean);
			if (r < 88)
				send_item(dssm_pkg::ACT_PUSH, side, rand_value());
			else if (r < 94)
				send_item(dssm_pkg::ACT_POP, side, rand_value());
			else
				send_item(dssm_pkg::ACT_DUMP, side, rand_value());
		end
		repeat (3) send_item(dssm_pkg::ACT_PUSH, rand_side(), rand_value());
		send_item(dssm_pkg::ACT_DUMP, 1'b0, rand_value());
		send_item(dssm_pkg::ACT_DUMP, 1'b1, rand_value());

		while (items_sent < 140) begin
			if (sb.occupancy() > DEPTH - 6)
				random_item(30, 45, 15);
			else
				random_item(45, 35, 15);
		end

		// drain both stacks
		while (sb.occupancy() > 0) begin
			side = rand_side();
			if (sb.count[side] == 0)
				side = !side;
			send_item(dssm_pkg::ACT_POP, side, rand_value());
		end
		send_item(dssm_pkg::ACT_POP, 1'b0, rand_value());
		send_item(dssm_pkg::ACT_POP, 1'b1, rand_value());
		send_item(dssm_pkg::ACT_DUMP, rand_side(), rand_value());
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d stack transactions plus %0d ignored ones; checked %0d results.",
			items_sent, items_ignored, sb.results_seen);
		$display("Refused pushes on a full store: %0d; longest dump: %0d elements.",
			sb.refused_pushes, sb.longest_dump);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
